/* src/setx_pkg.sv */
// Shared types, constants and lookup functions for the sprite entry tile expander.
// No dependencies; used by all setx_* modules and the top level.
package setx_pkg;

    localparam int unsigned CodeW = 13;
    localparam int unsigned PosW  = 10;
    localparam int unsigned MaskW = 32;
    localparam int unsigned InW   = 48;
    localparam int unsigned OutW  = 72;

    localparam logic CfgWideBank   = 1'b0;
    localparam logic CfgScreenFlip = 1'b1;

    typedef struct packed {
        logic [CodeW-1:0]       code;
        logic [1:0]             szsel;
        logic [3:0]             palette;
        logic                   fx;
        logic                   fy;
        logic signed [PosW-1:0] xpos;
        logic signed [PosW-1:0] ypos;
        logic [1:0]             prio;
    } t_desc;

    // 8x8 interleave: offset bits alternate x and y, x in the low bit
    function automatic logic [5:0] f_interleave(input logic [2:0] y, input logic [2:0] x);
        f_interleave = {y[2], x[2], y[1], x[1], y[0], x[0]};
    endfunction

    function automatic logic [MaskW-1:0] f_prio_mask(input logic [1:0] prio);
        logic [MaskW-1:0] m;
        unique case (prio)
            2'd1:    m = 32'h8000_00f0;
            2'd2:    m = 32'h8000_00fc;
            2'd3:    m = 32'h8000_00fe;
            default: m = '0;
        endcase
        f_prio_mask = m;
    endfunction

endpackage

/* src/sprite_entry_tile_expander_core.sv */
// Top level of the sprite entry tile expander: front end, descriptor queue, back end.
// Depends on setx_pkg, setx_front, setx_queue, setx_back.
//
//   channel   | dir | handshake                    | payload
//   s_axis    | in  | s_axis_tvalid/s_axis_tready  | six entry bytes
//   m_axis    | out | m_axis_tvalid/m_axis_tready  | one draw command, tlast = last sub-tile
//   cfg       | in  | i_cfg_we                     | 0 wide bank mode, 1 screen flip
//
// One draw command per cycle while m_axis_tready holds: a visible entry of S tiles per side gives S*S
// draw commands in the back-end sub-tile walk; an invisible entry is consumed with no output.
// Entries queue two deep while the back end works, so input stalls only when full.
// Reset is synchronous and clears configuration, queue and output valid.
module sprite_entry_tile_expander_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bank_byte, tile_byte, size_byte, flags_byte, ypos_byte, xpos_byte
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tile_code[12:0], palette[16:13], mirror_x[17], mirror_y[18],
    // screen_x[28:19], screen_y[38:29], prio_mask[70:39], zero pad[71]
    output logic [71:0] m_axis_tdata,
    // last_tile
    output logic        m_axis_tlast
);

    logic            w_push, w_full, w_pop, w_qvalid;
    setx_pkg::t_desc w_fdesc, w_qdesc;

    setx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .o_push     (w_push),
        .o_desc     (w_fdesc),
        .i_full     (w_full)
    );

    setx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_fdesc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_desc  (w_qdesc)
    );

    setx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_desc  (w_qdesc),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

/* src/setx_front.sv */
// Front end: holds the configuration registers, accepts entries, drops invisible ones
// and builds a per-sprite descriptor. Depends on setx_pkg.
module setx_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic                       i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [setx_pkg::InW-1:0]   i_data,
    output logic                       o_push,
    output setx_pkg::t_desc            o_desc,
    input  logic                       i_full
);

    logic r_wide_bank;
    logic r_screen_flip;

    logic [7:0] w_bank, w_tile, w_size, w_flags, w_ybyte, w_xbyte;
    logic [setx_pkg::CodeW-1:0] w_code_raw;
    logic [setx_pkg::CodeW-1:0] w_align;
    logic [setx_pkg::PosW-1:0]  w_xpos, w_ypos, w_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_bank   <= 1'b0;
            r_screen_flip <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                setx_pkg::CfgWideBank:   r_wide_bank   <= i_cfg_data;
                setx_pkg::CfgScreenFlip: r_screen_flip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_bank  = i_data[7:0];
    assign w_tile  = i_data[15:8];
    assign w_size  = i_data[23:16];
    assign w_flags = i_data[31:24];
    assign w_ybyte = i_data[39:32];
    assign w_xbyte = i_data[47:40];

    always_comb begin
        if (r_wide_bank) begin
            w_code_raw = {w_bank[7:3], 8'h00} + {5'b0, w_tile};
        end else begin
            w_code_raw = {1'b0, w_bank[7:4], 8'h00} + {5'b0, w_tile};
        end
        w_align = ~((setx_pkg::CodeW'(1) << {w_size[1:0], 1'b0}) - setx_pkg::CodeW'(1));
        w_span  = setx_pkg::PosW'(8) << w_size[1:0];
        w_xpos  = {{2{w_flags[4]}}, w_xbyte};
        w_ypos  = {{2{w_flags[5]}}, w_ybyte};
        if (r_screen_flip) begin
            w_xpos = setx_pkg::PosW'(256) - w_span - w_xpos;
            w_ypos = setx_pkg::PosW'(256) - w_span - w_ypos;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && w_bank[2];

    assign o_desc.code    = w_code_raw & w_align;
    assign o_desc.szsel   = w_size[1:0];
    assign o_desc.palette = w_flags[3:0];
    assign o_desc.fx      = w_bank[0] ^ r_screen_flip;
    assign o_desc.fy      = w_bank[1] ^ r_screen_flip;
    assign o_desc.xpos    = w_xpos;
    assign o_desc.ypos    = w_ypos;
    assign o_desc.prio    = w_flags[7:6];

endmodule

/* src/setx_queue.sv */
// Two-entry descriptor queue between front and back end.
// Depends on setx_pkg.
module setx_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  setx_pkg::t_desc  i_desc,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output setx_pkg::t_desc  o_desc
);

    logic            r_v0, r_v1;
    setx_pkg::t_desc r_q0, r_q1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_pop && r_v0) begin
            if (r_v1) begin
                r_v1 <= i_push;
            end else begin
                r_v0 <= i_push;
            end
        end else if (i_push) begin
            if (!r_v0) begin
                r_v0 <= 1'b1;
            end else begin
                r_v1 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop && r_v0) begin
            if (r_v1) begin
                r_q0 <= r_q1;
                if (i_push) begin
                    r_q1 <= i_desc;
                end
            end else if (i_push) begin
                r_q0 <= i_desc;
            end
        end else if (i_push) begin
            if (!r_v0) begin
                r_q0 <= i_desc;
            end else begin
                r_q1 <= i_desc;
            end
        end
    end

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_desc  = r_q0;

endmodule

/* src/setx_back.sv */
// Back end: walks the sub-tiles of the head descriptor in row order, one per cycle
// while the output is not stalled, into a registered output stage. Depends on setx_pkg.
module setx_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  setx_pkg::t_desc             i_desc,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [setx_pkg::OutW-1:0]   o_data,
    output logic                        o_last
);

    logic [2:0] r_x, r_y;
    logic       r_out_valid;
    logic       r_out_last;
    logic [setx_pkg::OutW-1:0] r_out_data;

    logic       w_load, w_emit, w_last;
    logic [2:0] w_side_m1, w_cx, w_cy;
    logic [setx_pkg::CodeW-1:0] w_code;
    logic [setx_pkg::PosW-1:0]  w_sx, w_sy;

    always_comb begin
        w_side_m1 = 3'((4'd1 << i_desc.szsel) - 4'd1);
        w_cx      = i_desc.fx ? (w_side_m1 - r_x) : r_x;
        w_cy      = i_desc.fy ? (w_side_m1 - r_y) : r_y;
        w_sx      = i_desc.xpos + {4'b0, w_cx, 3'b000};
        w_sy      = i_desc.ypos + {4'b0, w_cy, 3'b000};
        w_code    = i_desc.code + {7'b0, setx_pkg::f_interleave(r_y, r_x)};
        w_last    = (r_x == w_side_m1) && (r_y == w_side_m1);
    end

    assign w_load = !r_out_valid || i_ready;
    assign w_emit = w_load && i_valid;
    assign o_pop  = w_emit && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= 3'd0;
            r_y         <= 3'd0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                if (w_last) begin
                    r_x <= 3'd0;
                    r_y <= 3'd0;
                end else if (r_x == w_side_m1) begin
                    r_x <= 3'd0;
                    r_y <= r_y + 3'd1;
                end else begin
                    r_x <= r_x + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_last <= w_last;
            r_out_data <= {1'b0, setx_pkg::f_prio_mask(i_desc.prio), w_sy, w_sx,
                           i_desc.fy, i_desc.fx, i_desc.palette, w_code};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule
